>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int ENTRIES_W = 5;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_cmd_t;

endpackage

>>> hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk_i,
  input  spq_cmd_t            cmd_i,
  input  logic                valid_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [PAY_W-1:0]    new_payload_i,
  input  logic                left_push_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [PAY_W-1:0]    left_payload_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  input  logic [PAY_W-1:0]    right_payload_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic [PAY_W-1:0]    payload_o,
  output logic                push_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [PAY_W-1:0]    payload_q, payload_d;

  // slot is displaced by the new entry when empty or holding a larger key
  assign push_o = !valid_i || (key_q > new_key_i);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (cmd_i.ins && push_o) begin
      if (left_push_i) begin
        key_d     = left_key_i;
        payload_d = left_payload_i;
      end else begin
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end
    end else if (cmd_i.rem) begin
      key_d     = right_key_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

>>> hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted chain of slots, smallest key first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries op_i, key_i, payload_i.
//   op insert places the entry behind all entries with key less or equal,
//   op remove drops the front entry, op peek (and the unused code) only
//   reports. Every input beat yields exactly one output beat on the output
//   channel (out_valid_o / out_stall_i) with the front entry, the count,
//   an empty flag and a status (ok, full on insert, empty on any other op).
//   The output beat follows in the next cycle. Throughput is one beat
//   per cycle unless stalled: every slot compares its key with the new
//   key in the same cycle and shifts in one step, so the chain never
//   iterates. The result sits in an output register; while it is stalled
//   the input is stalled too, and it resumes the cycle the output beat
//   is taken. Reset clears the entry count and the output valid; slot
//   contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [PAY_W-1:0]     payload_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [KEY_W-1:0]     front_key_o,
  output logic [PAY_W-1:0]     front_payload_o,
  output logic [ENTRIES_W-1:0] entries_o,
  output logic                 empty_flag_o,
  output logic [STATUS_W-1:0]  status_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count_q, count_d;
  logic                out_valid_q;
  logic [KEY_W-1:0]    front_key_q, front_key_d;
  logic [PAY_W-1:0]    front_payload_q, front_payload_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic [KEY_BITS-1:0] new_key;
  logic                accept, full, empty;
  spq_cmd_t            cmd;

  logic [KEY_BITS-1:0] slot_key   [CAPACITY];
  logic [PAY_W-1:0]    slot_pay   [CAPACITY];
  logic [KEY_BITS-1:0] right_key  [CAPACITY];
  logic [PAY_W-1:0]    right_pay  [CAPACITY];
  logic [CAPACITY-1:0] slot_valid;
  logic [CAPACITY-1:0] push;
  logic [CAPACITY-1:0] left_push;

  assign new_key    = KEY_BITS'(key_i);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);

  assign cmd.ins = accept && (op_i == OP_INSERT) && !full;
  assign cmd.rem = accept && (op_i == OP_REMOVE) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign slot_valid[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_push[i] = 1'b0;
    end else begin : g_mid
      assign left_push[i] = push[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key[i] = slot_key[i];
      assign right_pay[i] = slot_pay[i];
    end else begin : g_next
      assign right_key[i] = slot_key[i+1];
      assign right_pay[i] = slot_pay[i+1];
    end

    spq_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .cmd_i          (cmd),
      .valid_i        (slot_valid[i]),
      .new_key_i      (new_key),
      .new_payload_i  (payload_i),
      .left_push_i    (left_push[i]),
      .left_key_i     ((i == 0) ? new_key : slot_key[(i == 0) ? 0 : i-1]),
      .left_payload_i ((i == 0) ? payload_i : slot_pay[(i == 0) ? 0 : i-1]),
      .right_key_i    (right_key[i]),
      .right_payload_i(right_pay[i]),
      .key_o          (slot_key[i]),
      .payload_o      (slot_pay[i]),
      .push_o         (push[i])
    );
  end

  always_comb begin
    logic [KEY_BITS-1:0] fk;
    logic [PAY_W-1:0]    fp;
    count_d = count_q;
    fk      = slot_key[0];
    fp      = slot_pay[0];
    if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
      if (push[0]) begin
        fk = new_key;
        fp = payload_i;
      end
    end else if (cmd.rem) begin
      count_d = count_q - CNT_W'(1);
      fk      = right_key[0];
      fp      = right_pay[0];
    end

    if (op_i == OP_INSERT) begin
      status_d = full ? ST_FULL : ST_OK;
    end else begin
      status_d = empty ? ST_EMPTY : ST_OK;
    end

    if (count_d == '0) begin
      front_key_d     = '0;
      front_payload_d = '0;
    end else begin
      front_key_d     = KEY_W'(fk);
      front_payload_d = fp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result fields, held while stalled
  logic [CNT_W-1:0] count_out_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_key_q     <= front_key_d;
      front_payload_q <= front_payload_d;
      status_q        <= status_d;
      count_out_q     <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign front_key_o     = front_key_q;
  assign front_payload_o = front_payload_q;
  assign entries_o       = ENTRIES_W'(count_out_q);
  assign empty_flag_o    = (count_out_q == '0);
  assign status_o        = status_q;

endmodule

>>> hw/rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [KEY_W-1:0]     front_key_o,
  input logic [PAY_W-1:0]     front_payload_o,
  input logic [ENTRIES_W-1:0] entries_o,
  input logic                 empty_flag_o,
  input logic [STATUS_W-1:0]  status_o
);

  localparam bit SMALL = (CAPACITY < 32);

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!SMALL || (int'(entries_o) <= CAPACITY)))
    else $error("entry count above capacity");

  // empty beat reports a zero front entry and no full status
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_flag_o) |->
      (front_key_o == '0 && front_payload_o == '0 && status_o != ST_FULL))
    else $error("empty queue with nonzero front or full status");

  // full status only with a full queue
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |->
      (!empty_flag_o && (!SMALL || int'(entries_o) == CAPACITY)))
    else $error("full status with queue not full");

  // every accepted beat gives an output beat next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted beat without result");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(front_key_o) && $stable(entries_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .front_key_o    (front_key_o),
  .front_payload_o(front_payload_o),
  .entries_o      (entries_o),
  .empty_flag_o   (empty_flag_o),
  .status_o       (status_o)
);
